// ===== src/euler_to_quaternion_assert.svh =====
// ---------------------------------------------------------------------------
// Euler-to-quaternion assertion macros
// Shared property templates for the port checker.
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define E2Q_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("e2q check failed");

// next-cycle implication
`define E2Q_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("e2q check failed");

`endif

// ===== src/e2q_pkg.sv =====
// ---------------------------------------------------------------------------
// e2q_pkg
// Constants, the arctangent table and the fixed-point helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;

	localparam int ANG_W = 33;   // angle / binary-unit width
	localparam int CS_W  = 33;   // CORDIC x/y width
	localparam int PR_W  = 34;   // product width

	localparam logic [26:0] RECIP45 = 27'd95443718;  // ceil(2^32/45)
	localparam logic signed [CS_W-1:0] GAIN_Q30 = 33'sd652032874;
	localparam logic signed [ANG_W-1:0] QTR_TURN  = 33'sd1073741824;
	localparam logic signed [ANG_W-1:0] HALF_TURN = 33'sd2147483648;
	localparam logic signed [34:0] ONE_Q30  = 35'sd1073741824;
	localparam logic signed [34:0] MONE_Q30 = -35'sd1073741824;

	function automatic logic [29:0] atan_at(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// Q2.30 product, round half up then floor shift
	function automatic logic signed [PR_W-1:0] mulq(input logic signed [PR_W-1:0] a,
			input logic signed [PR_W-1:0] b);
		logic signed [2*PR_W-1:0] p;
		p = (2*PR_W)'(a) * (2*PR_W)'(b) + 68'sd536870912;
		return PR_W'(p >>> 30);
	endfunction

	function automatic logic [31:0] sat1(input logic signed [34:0] v);
		logic signed [34:0] r;
		if (v > ONE_Q30) r = ONE_Q30;
		else if (v < MONE_Q30) r = MONE_Q30;
		else r = v;
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/e2q_reduce.sv =====
// ---------------------------------------------------------------------------
// e2q_reduce
// Four-stage angle reduction: rem 360 deg, halve, scale to binary units, fold.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_reduce (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [31:0]                angle,
	output logic signed [e2q_pkg::ANG_W-1:0]       z,
	output logic                                   flip
);
	import e2q_pkg::*;

	// stage 1: magnitude and quotient by 360 deg (= 45 * 2^19)
	logic [31:0] mag_c;
	logic [39:0] prod1_c;
	logic [31:0] mag_s1;
	logic [7:0]  q_s1;
	logic        neg_s1;

	assign mag_c   = angle[31] ? 32'(-angle) : 32'(angle);
	assign prod1_c = 40'(mag_c[31:19]) * 40'(RECIP45);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			q_s1   <= prod1_c[39:32];
			neg_s1 <= angle[31];
		end
	end

	// stage 2: remainder
	logic [31:0] sub_c;
	logic [24:0] r_s2;
	logic        neg_s2;

	assign sub_c = mag_s1 - {1'b0, 12'(q_s1) * 12'd45, 19'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2   <= sub_c[24:0];
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: r / 45
	logic [51:0] prod2_c;
	logic [24:0] r_s3;
	logic [19:0] a_s3;
	logic        neg_s3;

	assign prod2_c = 52'(r_s2) * 52'(RECIP45);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= r_s2;
			a_s3   <= prod2_c[51:32];
			neg_s3 <= neg_s2;
		end
	end

	// stage 4: r*4096/45 = a*4096 + c*91, restore sign, fold half turn
	logic [24:0] c_full;
	logic [31:0] bmag_c;
	logic signed [ANG_W-1:0] b_c;

	assign c_full = r_s3 - 25'(a_s3) * 25'd45;
	assign bmag_c = {a_s3, 12'd0} + 32'(c_full[5:0]) * 32'd91;
	assign b_c    = neg_s3 ? -$signed({1'b0, bmag_c}) : $signed({1'b0, bmag_c});

	always_ff @(posedge clk) begin
		if (en) begin
			if (b_c > QTR_TURN) begin
				z    <= b_c - HALF_TURN;
				flip <= 1'b1;
			end else if (b_c < -QTR_TURN) begin
				z    <= b_c + HALF_TURN;
				flip <= 1'b1;
			end else begin
				z    <= b_c;
				flip <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/e2q_cordic.sv =====
// ---------------------------------------------------------------------------
// e2q_cordic
// Rotation-mode CORDIC, one registered stage per iteration.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_cordic #(
	parameter int ITERATIONS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [e2q_pkg::ANG_W-1:0]  z_in,
	input  wire logic                              flip_in,
	output logic signed [e2q_pkg::CS_W-1:0]        sin,
	output logic signed [e2q_pkg::CS_W-1:0]        cos
);
	import e2q_pkg::*;

	logic signed [CS_W-1:0] x_s [ITERATIONS];
	logic signed [CS_W-1:0] y_s [ITERATIONS];
	logic signed [ANG_W:0]  z_s [ITERATIONS];
	logic                   f_s [ITERATIONS];

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
		logic signed [CS_W-1:0] xp, yp, xn, yn;
		logic signed [ANG_W:0]  zp, zn, at;
		logic                   fp;

		if (i == 0) begin : g_first
			assign xp = GAIN_Q30;
			assign yp = '0;
			assign zp = (ANG_W+1)'(z_in);
			assign fp = flip_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign fp = f_s[i-1];
		end

		assign at = $signed({4'd0, atan_at(5'(i))});

		always_comb begin
			if (zp >= 0) begin
				xn = xp - (yp >>> i);
				yn = yp + (xp >>> i);
				zn = zp - at;
			end else begin
				xn = xp + (yp >>> i);
				yn = yp - (xp >>> i);
				zn = zp + at;
			end
		end

		// last stage applies the half-turn fold sign
		always_ff @(posedge clk) begin
			if (en) begin
				if (i == ITERATIONS - 1 && fp) begin
					x_s[i] <= -xn;
					y_s[i] <= -yn;
				end else begin
					x_s[i] <= xn;
					y_s[i] <= yn;
				end
				z_s[i] <= zn;
				f_s[i] <= fp;
			end
		end
	end

	assign cos = x_s[ITERATIONS-1];
	assign sin = y_s[ITERATIONS-1];

endmodule
`default_nettype wire

// ===== src/e2q_qmul.sv =====
// ---------------------------------------------------------------------------
// e2q_qmul
// Triple products, sums and saturation in three stages.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_qmul (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [e2q_pkg::CS_W-1:0]   sp,
	input  wire logic signed [e2q_pkg::CS_W-1:0]   cp,
	input  wire logic signed [e2q_pkg::CS_W-1:0]   sy,
	input  wire logic signed [e2q_pkg::CS_W-1:0]   cy,
	input  wire logic signed [e2q_pkg::CS_W-1:0]   sr,
	input  wire logic signed [e2q_pkg::CS_W-1:0]   cr,
	output logic [31:0]                            quat_x,
	output logic [31:0]                            quat_y,
	output logic [31:0]                            quat_z,
	output logic [31:0]                            quat_w
);
	import e2q_pkg::*;

	// stage 1: roll by pitch
	logic signed [PR_W-1:0] crsp_s1, srcp_s1, crcp_s1, srsp_s1;
	logic signed [PR_W-1:0] sy_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			crsp_s1 <= mulq(PR_W'(cr), PR_W'(sp));
			srcp_s1 <= mulq(PR_W'(sr), PR_W'(cp));
			crcp_s1 <= mulq(PR_W'(cr), PR_W'(cp));
			srsp_s1 <= mulq(PR_W'(sr), PR_W'(sp));
			sy_s1   <= PR_W'(sy);
			cy_s1   <= PR_W'(cy);
		end
	end

	// stage 2: times yaw
	logic signed [PR_W-1:0] x0_s2, x1_s2, y0_s2, y1_s2, z0_s2, z1_s2, w0_s2, w1_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s2 <= mulq(crsp_s1, sy_s1);
			x1_s2 <= mulq(srcp_s1, cy_s1);
			y0_s2 <= mulq(crsp_s1, cy_s1);
			y1_s2 <= mulq(srcp_s1, sy_s1);
			z0_s2 <= mulq(crcp_s1, sy_s1);
			z1_s2 <= mulq(srsp_s1, cy_s1);
			w0_s2 <= mulq(crcp_s1, cy_s1);
			w1_s2 <= mulq(srsp_s1, sy_s1);
		end
	end

	// stage 3: combine and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			quat_x <= sat1(35'(x0_s2) - 35'(x1_s2));
			quat_y <= sat1(-35'(y0_s2) - 35'(y1_s2));
			quat_z <= sat1(35'(z0_s2) - 35'(z1_s2));
			quat_w <= sat1(35'(w0_s2) + 35'(w1_s2));
		end
	end

endmodule
`default_nettype wire

// ===== src/euler_to_quaternion.sv =====
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Pitch/yaw/roll in degrees (Q16.16) to a rotation quaternion (Q2.30).
// ---------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  s_*      in   pitch_deg, yaw_deg, roll_deg       (3 x 32 bits)
//  m_*      out  quat_x, quat_y, quat_z, quat_w     (4 x 32 bits)
//
// One transfer accepted per cycle while the output is not stalled; the pipeline
// has four stages of angle reduction, one per CORDIC iteration, three of products.
// The pipeline advances as one; it holds whenever a result waits unaccepted.
// Reset clears only the valid bits; data registers carry no reset.
`default_nettype none
module euler_to_quaternion #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // pitch_deg, yaw_deg, roll_deg
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata    // quat_x, quat_y, quat_z, quat_w
);
	import e2q_pkg::*;

	localparam int LATENCY = 7 + CORDIC_ITERATIONS;

	logic               en;
	logic [LATENCY-1:0] vld_q;

	// advance when the output slot is empty or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], s_tvalid};
		end
	end

	// reduce each angle to a folded half angle
	logic signed [ANG_W-1:0] zp, zy, zr;
	logic                    fp, fy, fr;

	e2q_reduce u_red_p (.clk, .en, .angle(s_tdata[31:0]),  .z(zp), .flip(fp));
	e2q_reduce u_red_y (.clk, .en, .angle(s_tdata[63:32]), .z(zy), .flip(fy));
	e2q_reduce u_red_r (.clk, .en, .angle(s_tdata[95:64]), .z(zr), .flip(fr));

	// sine and cosine of each half angle
	logic signed [CS_W-1:0] sp, cp, sy, cy, sr, cr;

	e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cor_p (
		.clk, .en, .z_in(zp), .flip_in(fp), .sin(sp), .cos(cp));
	e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cor_y (
		.clk, .en, .z_in(zy), .flip_in(fy), .sin(sy), .cos(cy));
	e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cor_r (
		.clk, .en, .z_in(zr), .flip_in(fr), .sin(sr), .cos(cr));

	// triple products; the last stage is the output register
	e2q_qmul u_qmul (
		.clk, .en,
		.sp, .cp, .sy, .cy, .sr, .cr,
		.quat_x(m_tdata[31:0]),
		.quat_y(m_tdata[63:32]),
		.quat_z(m_tdata[95:64]),
		.quat_w(m_tdata[127:96])
	);

endmodule
`default_nettype wire

// ===== src/e2q_checker.sv =====
// ---------------------------------------------------------------------------
// e2q_checker
// Port-level checks, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "euler_to_quaternion_assert.svh"
module e2q_port_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata
);

	// hold a stalled result
	`E2Q_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`E2Q_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// an empty output slot never blocks input
	`E2Q_ASSERT_NOW(a_in_ready, clk, arst_n, !m_tvalid, s_tready)

	// W stays within plus or minus one
	`E2Q_ASSERT_NOW(a_w_range, clk, arst_n, m_tvalid,
		$signed(m_tdata[127:96]) <= 32'sd1073741824 &&
		$signed(m_tdata[127:96]) >= -32'sd1073741824)

	// a stall backs up the input too
	`E2Q_ASSERT_NOW(a_in_stall, clk, arst_n, m_tvalid && !m_tready, !s_tready)

endmodule

bind euler_to_quaternion e2q_port_checker u_e2q_checker (.*);
`default_nettype wire
